// File: rtl/akc_pkg.sv
// Shared types, codes and letter arithmetic for the autokey letter engine.
`timescale 1ns / 1ps

package akc_pkg;

	localparam int unsigned ALPHABET = 26;

	typedef logic [4:0] letter_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEXT = 1'b1
	} op_t;

	typedef enum logic {
		DIR_ENCRYPT = 1'b0,
		DIR_DECRYPT = 1'b1
	} dir_t;

	// Controls shared by every cell of the key line.
	typedef struct packed {
		logic    shift;
		logic    restart;
		letter_t plain;
		letter_t load_letter;
	} cell_ctrl_t;

	// Codes 26..31 wrap back into the alphabet.
	function automatic letter_t fold_letter(input letter_t v);
		letter_t r;
		r = (v >= letter_t'(ALPHABET)) ? v - letter_t'(ALPHABET) : v;
		return r;
	endfunction

	function automatic letter_t add_mod(input letter_t a, input letter_t b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 6'(ALPHABET)) begin
			s = s - 6'(ALPHABET);
		end
		return s[4:0];
	endfunction

	function automatic letter_t sub_mod(input letter_t a, input letter_t b);
		logic [5:0] s;
		s = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + 6'(ALPHABET) - {1'b0, b};
		return s[4:0];
	endfunction

endpackage

// File: rtl/akc_ifs.sv
// Handshake interfaces for the request, result and configuration channels.
`timescale 1ns / 1ps

interface akc_req_if;
	import akc_pkg::*;
	logic    valid;
	logic    ready;
	op_t     operation;
	letter_t letter;
	logic    message_start;
	modport source (output valid, output operation, output letter, output message_start,
		input ready);
	modport sink (input valid, input operation, input letter, input message_start,
		output ready);
endinterface

interface akc_rsp_if;
	import akc_pkg::*;
	logic    valid;
	logic    ready;
	letter_t out_letter;
	modport source (output valid, output out_letter, input ready);
	modport sink (input valid, input out_letter, output ready);
endinterface

interface akc_cfg_if;
	logic valid;
	logic ready;
	logic direction;
	modport source (output valid, output direction, input ready);
	modport sink (input valid, input direction, output ready);
endinterface

// File: rtl/autokey_cipher_letter_engine_core.sv
// Top level of the autokey letter engine: control, key line of cells and result register.
`timescale 1ns / 1ps

// Autokey Vigenere engine over letter indices 0 (a) to 25 (z).
// Requests arrive on req: a load appends one primer letter (message_start clears the
// primer first, loads beyond PRIMER_MAX are dropped); a text request gives one letter
// and yields one result on rsp. message_start on text restarts the key stream.
// The cfg channel sets direction (0 encrypt, 1 decrypt); it is always ready and should
// only be written while no request is in flight.
// The key stream lives in a line of PRIMER_MAX cells that shifts one place per text
// letter, so the head cell holds the key for the next letter but on a restart (head primer).
// A result is registered and appears on rsp in the cycle after its request is accepted.
// Throughput: one request per cycle while the receiver takes each result; the tail cell
// takes the plaintext, which in decrypt is the mod-26 subtraction of the head key.
// Stalls: the result register frees as the receiver takes its result, so req is ready
// whenever rsp is empty or being taken in the same cycle.
// Reset clears the primer length and the result valid flag and sets direction to decrypt.
module autokey_cipher_letter_engine_core
	import akc_pkg::*;
#(
	parameter int unsigned PRIMER_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	akc_req_if.sink     req,
	akc_rsp_if.source   rsp,
	akc_cfg_if.sink     cfg
);

	localparam int unsigned LEN_W = $clog2(PRIMER_MAX + 1);

	logic [LEN_W-1:0] len_q;
	logic             fresh_q;
	dir_t             direction_q;
	logic             out_valid_q;
	letter_t          out_letter_q;

	letter_t          primers [PRIMER_MAX];
	letter_t          keys    [PRIMER_MAX];
	logic             load_sel [PRIMER_MAX];
	logic             is_tail  [PRIMER_MAX];

	cell_ctrl_t       ctrl;
	logic             accept;
	logic             load_acc;
	logic             text_acc;
	logic             restart;
	logic             empty;
	letter_t          ch;
	letter_t          head_key;
	letter_t          plain;
	letter_t          result;

	assign req.ready = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	assign accept   = req.valid && req.ready;
	assign load_acc = accept && (req.operation == OP_LOAD);
	assign text_acc = accept && (req.operation == OP_TEXT);
	assign empty    = (len_q == '0);
	assign restart  = req.message_start || fresh_q;
	assign ch       = fold_letter(req.letter);
	assign head_key = restart ? primers[0] : keys[0];

	always_comb begin
		unique case (direction_q)
			DIR_ENCRYPT: begin
				plain  = ch;
				result = add_mod(ch, head_key);
			end
			DIR_DECRYPT: begin
				plain  = sub_mod(ch, head_key);
				result = plain;
			end
			default: begin
				plain  = ch;
				result = ch;
			end
		endcase
		if (empty) begin
			result = ch;
		end
	end

	assign ctrl.shift       = text_acc && !empty;
	assign ctrl.restart     = restart;
	assign ctrl.plain       = plain;
	assign ctrl.load_letter = ch;

	for (genvar i = 0; i < PRIMER_MAX; i++) begin : g_cell
		letter_t nb_primer;
		letter_t nb_key;

		if (i == PRIMER_MAX - 1) begin : g_last
			assign nb_primer = '0;
			assign nb_key    = '0;
		end else begin : g_mid
			assign nb_primer = primers[i+1];
			assign nb_key    = keys[i+1];
		end

		assign is_tail[i]  = (len_q == LEN_W'(i + 1));
		assign load_sel[i] = load_acc &&
			(req.message_start ? (i == 0) : (len_q == LEN_W'(i)));

		akc_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.load_sel    (load_sel[i]),
			.is_tail     (is_tail[i]),
			.next_primer (nb_primer),
			.next_key    (nb_key),
			.primer      (primers[i]),
			.key         (keys[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			fresh_q     <= 1'b1;
			direction_q <= DIR_DECRYPT;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				direction_q <= dir_t'(cfg.direction);
			end
			if (load_acc) begin
				fresh_q <= 1'b1;
				if (req.message_start) begin
					len_q <= LEN_W'(1);
				end else if (len_q != LEN_W'(PRIMER_MAX)) begin
					len_q <= len_q + LEN_W'(1);
				end
			end else if (ctrl.shift) begin
				fresh_q <= 1'b0;
			end
			if (text_acc) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_acc) begin
			out_letter_q <= result;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_letter = out_letter_q;

endmodule

// File: rtl/akc_cell.sv
// One cell of the key line: a primer letter and a key letter that shifts towards the head.
`timescale 1ns / 1ps

module akc_cell
	import akc_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       load_sel,
	input  logic       is_tail,
	input  letter_t    next_primer,
	input  letter_t    next_key,
	output letter_t    primer,
	output letter_t    key
);

	letter_t primer_q;
	letter_t key_q;

	always_ff @(posedge clk) begin
		if (load_sel) begin
			primer_q <= ctrl.load_letter;
		end
		// The tail cell takes the fresh plaintext; the others take their neighbour's key,
		// or its primer letter when the stream restarts with this letter.
		if (ctrl.shift) begin
			if (is_tail) begin
				key_q <= ctrl.plain;
			end else if (ctrl.restart) begin
				key_q <= next_primer;
			end else begin
				key_q <= next_key;
			end
		end
	end

	assign primer = primer_q;
	assign key    = key_q;

endmodule
